@@ src/fifc_pkg.sv @@
// Package with opcodes, format constants and helper functions for the format converter.
`default_nettype none
package fifc_pkg;

  localparam int OpWidth   = 4;
  localparam int DataWidth = 64;

  localparam logic [3:0] OP_S32_F64 = 4'd0;
  localparam logic [3:0] OP_S64_F64 = 4'd1;
  localparam logic [3:0] OP_U32_F64 = 4'd2;
  localparam logic [3:0] OP_U64_F64 = 4'd3;
  localparam logic [3:0] OP_F64_S32 = 4'd4;
  localparam logic [3:0] OP_F64_S64 = 4'd5;
  localparam logic [3:0] OP_F64_U32 = 4'd6;
  localparam logic [3:0] OP_F64_U64 = 4'd7;
  localparam logic [3:0] OP_F32_F64 = 4'd8;
  localparam logic [3:0] OP_F64_F32 = 4'd9;

  localparam logic [10:0] D_BIAS    = 11'd1023;
  localparam logic [10:0] D_EXP_MAX = 11'h7FF;
  localparam logic [7:0]  F_BIAS    = 8'd127;
  localparam logic [7:0]  F_EXP_MAX = 8'hFF;

  // Index of the most significant set bit; zero for a zero input.
  function automatic logic [5:0] msb_index(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(i);
    end
    return n;
  endfunction

  // Index of the most significant set bit of a 23-bit mantissa.
  function automatic logic [4:0] msb_index23(input logic [22:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ src/fifc_core.sv @@
// Combinational conversion datapath for all opcodes.
`default_nettype none
module fifc_core (
  input  wire logic [3:0]  req_type,
  input  wire logic [63:0] operand,
  output logic      [63:0] result
);

  logic [31:0] lo;
  logic        neg64, neg32, int_sign;
  logic [63:0] int_mag;
  logic [5:0]  int_e;
  logic [63:0] int_norm;
  logic [63:0] i2d;
  logic [10:0] d_exp;
  logic [51:0] d_man;
  logic [52:0] d_sig;
  logic [11:0] d_ue;
  logic [63:0] d_mag;
  logic [63:0] d2i_s64, d2i_u64;
  logic [31:0] d2i_s32, d2i_u32;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [4:0]  f_msb;
  logic [22:0] f_norm;
  logic [10:0] f_dexp;
  logic [63:0] f2d;
  logic [12:0] ne;
  logic [31:0] d2f;

  assign lo    = operand[31:0];
  assign neg64 = operand[63];
  assign neg32 = lo[31];

  // Integer to double: sign, magnitude, leading-one search, normalizing shift.
  always_comb begin
    int_sign = 1'b0;
    int_mag  = 64'd0;
    case (req_type)
      fifc_pkg::OP_S32_F64: begin
        int_sign = neg32;
        int_mag  = {32'd0, neg32 ? (32'd0 - lo) : lo};
      end
      fifc_pkg::OP_S64_F64: begin
        int_sign = neg64;
        int_mag  = neg64 ? (64'd0 - operand) : operand;
      end
      fifc_pkg::OP_U32_F64: int_mag = {32'd0, lo};
      default: int_mag = operand;
    endcase
    int_e    = fifc_pkg::msb_index(int_mag);
    int_norm = int_mag << (6'd63 - int_e);
    if (int_mag == 64'd0) i2d = 64'd0;
    else i2d = {int_sign, 11'(int_e) + fifc_pkg::D_BIAS, int_norm[62:11]};
  end

  // Double to integer: truncated magnitude.
  assign d_exp = operand[62:52];
  assign d_man = operand[51:0];
  assign d_sig = {1'b1, d_man};
  assign d_ue  = {1'b0, d_exp} - {1'b0, fifc_pkg::D_BIAS};
  always_comb begin
    if (d_exp < fifc_pkg::D_BIAS) d_mag = 64'd0;
    else if (d_ue <= 12'd52) d_mag = {11'd0, d_sig} >> (6'd52 - d_ue[5:0]);
    else if (d_ue - 12'd52 >= 12'd64) d_mag = 64'd0;
    else d_mag = {11'd0, d_sig} << (d_ue[5:0] - 6'd52);
  end
  assign d2i_s64 = neg64 ? (64'd0 - d_mag) : d_mag;
  assign d2i_s32 = neg64 ? (32'd0 - d_mag[31:0]) : d_mag[31:0];
  assign d2i_u64 = neg64 ? 64'd0 : d_mag;
  assign d2i_u32 = neg64 ? 32'd0 : d_mag[31:0];

  // Single to double; subnormals normalize with a leading-one search.
  assign f_exp = lo[30:23];
  assign f_man = lo[22:0];
  assign f_msb = fifc_pkg::msb_index23(f_man);
  always_comb begin
    f_norm = 23'(f_man << (5'd23 - f_msb));
    f_dexp = 11'd0;
    if (f_exp == 8'd0) begin
      if (f_man == 23'd0) f2d = {lo[31], 63'd0};
      else begin
        f_dexp = 11'd1023 - 11'd127 + 11'(f_msb) - 11'd22;
        f2d = {lo[31], f_dexp, f_norm, 29'd0};
      end
    end else if (f_exp == fifc_pkg::F_EXP_MAX) begin
      f2d = {lo[31], fifc_pkg::D_EXP_MAX, f_man, 29'd0};
    end else begin
      f_dexp = 11'(f_exp) + 11'd896;
      f2d = {lo[31], f_dexp, f_man, 29'd0};
    end
  end

  // Double to single with flush to zero and saturation to infinity.
  assign ne = {2'b00, d_exp} - 13'd896;
  always_comb begin
    if (d_exp == 11'd0) d2f = {neg64, 31'd0};
    else if (d_exp == fifc_pkg::D_EXP_MAX) d2f = {neg64, fifc_pkg::F_EXP_MAX, d_man[51:29]};
    else if (ne[12] || ne == 13'd0) d2f = {neg64, 31'd0};
    else if (ne >= 13'd255) d2f = {neg64, fifc_pkg::F_EXP_MAX, 23'd0};
    else d2f = {neg64, ne[7:0], d_man[51:29]};
  end

  always_comb begin
    case (req_type)
      fifc_pkg::OP_S32_F64, fifc_pkg::OP_S64_F64,
      fifc_pkg::OP_U32_F64, fifc_pkg::OP_U64_F64: result = i2d;
      fifc_pkg::OP_F64_S32: result = {32'd0, d2i_s32};
      fifc_pkg::OP_F64_S64: result = d2i_s64;
      fifc_pkg::OP_F64_U32: result = {32'd0, d2i_u32};
      fifc_pkg::OP_F64_U64: result = d2i_u64;
      fifc_pkg::OP_F32_F64: result = f2d;
      fifc_pkg::OP_F64_F32: result = {32'd0, d2f};
      default: result = 64'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/float_int_format_converter_unit.sv @@
// Top level of the integer / floating-point format converter.
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_req_type, in_operand
//   out      output     out_valid, out_stall, out_result
//
// One beat per cycle unless stalled; input and output are registered.
// The rate is set by the input register feeding a single conversion pass.
// A full skid register, filled on an output stall, stalls the input side.
// Reset clears the valid bits only.
`default_nettype none
module float_int_format_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [63:0] in_operand,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] out_result
);

  logic [3:0]  op_r;
  logic [63:0] opnd_r;
  logic        v_r;
  logic [63:0] res;
  logic        skid_v_r;
  logic [63:0] skid_r;
  logic        out_v_r;
  logic [63:0] out_r;
  logic        adv;

  fifc_core u_core (.req_type(op_r), .operand(opnd_r), .result(res));

  assign in_stall   = skid_v_r;
  assign out_valid  = out_v_r;
  assign out_result = out_r;
  assign adv        = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= 1'b0;
      skid_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (!skid_v_r) v_r <= in_valid;
      if (adv) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else out_v_r <= v_r;
      end else if (v_r && !skid_v_r) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      op_r   <= in_req_type;
      opnd_r <= in_operand;
    end
    if (adv) out_r <= skid_v_r ? skid_r : res;
    else if (v_r && !skid_v_r) skid_r <= res;
  end

  // A result held in the skid register means the input side is stalled.
  assert property (@(posedge clk) disable iff (!rst_n) skid_v_r |-> in_stall)
    else $error("skid full without input stall");
  // A stalled output result must stay put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("stalled result changed");
  // The skid register only fills while the output is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid filled without output stall");

endmodule
`default_nettype wire

@@ sim/float_int_format_converter_unit_test.sv @@
// Self-checking testbench for the integer / floating-point format converter.
`timescale 1ns / 1ps
module float_int_format_converter_unit_test;

  class conversion_board;
    logic [63:0] pending[$];
    int errors = 0;

    // Highest set bit of a nonzero value.
    function automatic int top_bit(logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i;
      return n;
    endfunction

    function automatic logic [63:0] mag_to_f64(logic sgn, logic [63:0] mag);
      int e;
      logic [51:0] m;
      if (mag == 0) return 64'd0;
      e = top_bit(mag);
      if (e <= 52) m = 52'(mag << (52 - e));
      else m = 52'(mag >> (e - 52));
      return {sgn, 11'(e + 1023), m};
    endfunction

    // Truncated integer magnitude; zero below one or when shifted out.
    function automatic logic [63:0] f64_mag(logic [63:0] u);
      int e;
      logic [63:0] m;
      e = int'(u[62:52]);
      m = {11'd0, 1'b1, u[51:0]};
      if (e < 1023) return 64'd0;
      e -= 1023;
      if (e <= 52) return m >> (52 - e);
      if (e - 52 >= 64) return 64'd0;
      return m << (e - 52);
    endfunction

    function automatic logic [63:0] f32_to_f64(logic [31:0] u);
      int e;
      logic [22:0] m;
      e = int'(u[30:23]);
      m = u[22:0];
      if (e == 0) begin
        if (m == 0) return {u[31], 63'd0};
        // Normalize the subnormal; the shifted-out leading one is dropped.
        while (!m[22]) begin
          m = m << 1;
          e--;
        end
        m = m << 1;
        return {u[31], 11'(e - 127 + 1023), m, 29'd0};
      end
      if (e == 255) return {u[31], 11'h7FF, m, 29'd0};
      return {u[31], 11'(e - 127 + 1023), m, 29'd0};
    endfunction

    function automatic logic [63:0] f64_to_f32(logic [63:0] u);
      int e, ne;
      e = int'(u[62:52]);
      if (e == 0) return {32'd0, u[63], 31'd0};
      if (e == 2047) return {32'd0, u[63], 8'hFF, u[51:29]};
      ne = e - 1023 + 127;
      if (ne <= 0) return {32'd0, u[63], 31'd0};
      if (ne >= 255) return {32'd0, u[63], 8'hFF, 23'd0};
      return {32'd0, u[63], 8'(ne), u[51:29]};
    endfunction

    function automatic logic [63:0] convert(logic [3:0] op, logic [63:0] x);
      logic [63:0] lo, mag;
      lo = {32'd0, x[31:0]};
      case (op)
        fifc_pkg::OP_S32_F64:
          return mag_to_f64(x[31], x[31] ? {32'd0, 32'(-x[31:0])} : lo);
        fifc_pkg::OP_S64_F64: return mag_to_f64(x[63], x[63] ? -x : x);
        fifc_pkg::OP_U32_F64: return mag_to_f64(1'b0, lo);
        fifc_pkg::OP_U64_F64: return mag_to_f64(1'b0, x);
        fifc_pkg::OP_F64_S32: begin
          mag = f64_mag(x);
          return {32'd0, x[63] ? 32'(-mag[31:0]) : mag[31:0]};
        end
        fifc_pkg::OP_F64_S64: begin
          mag = f64_mag(x);
          return x[63] ? -mag : mag;
        end
        fifc_pkg::OP_F64_U32: begin
          mag = f64_mag(x);
          return x[63] ? 64'd0 : {32'd0, mag[31:0]};
        end
        fifc_pkg::OP_F64_U64: return x[63] ? 64'd0 : f64_mag(x);
        fifc_pkg::OP_F32_F64: return f32_to_f64(x[31:0]);
        fifc_pkg::OP_F64_F32: return f64_to_f32(x);
        default: return 64'd0;
      endcase
    endfunction

    function void note_input(logic [3:0] op, logic [63:0] x);
      pending.push_back(convert(op, x));
    endfunction

    function void check_result(logic [63:0] r);
      logic [63:0] want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", 64'd0, r);
        return;
      end
      want = pending.pop_front();
      if (r !== want) report_mismatch("result field differs", want, r);
    endfunction

    function void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("MISMATCH: %s: expected %h got %h", what, want, got);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [3:0] in_req_type = 0;
  logic [63:0] in_operand = 0;
  logic out_stall = 0;
  wire in_stall;
  wire out_valid;
  wire [63:0] out_result;

  conversion_board board = new();
  int cycle_count = 0;
  int hold_off = 0;
  bit calm = 0;
  bit sending_done = 0;

  float_int_format_converter_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_operand(in_operand), .out_valid(out_valid),
    .out_stall(out_stall), .out_result(out_result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_result);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Doubles with exponents around the interesting range.
  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(5))
      0: v[62:52] = 11'($urandom_range(1023 + 70, 1023 - 3));
      1: v[62:52] = 11'($urandom_range(1023 + 130, 1023 - 130));
      2: v[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
      3: v[62:52] = 11'($urandom_range(1023 + 66, 1023 + 62));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_operand(logic [3:0] op);
    logic [63:0] v;
    v = rand64();
    if (op >= fifc_pkg::OP_F64_S32 && op <= fifc_pkg::OP_F64_U64 ||
        op == fifc_pkg::OP_F64_F32) return rand_double();
    if (op == fifc_pkg::OP_F32_F64 && $urandom_range(2) == 0)
      v[30:23] = $urandom_range(1) ? 8'hFF : 8'd0;
    if ($urandom_range(3) == 0) v = v >> $urandom_range(63);
    return v;
  endfunction

  task automatic send_beat(logic [3:0] op, logic [63:0] x);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_operand <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(op, x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] edge_vals[8];
    logic [3:0] op;
    edge_vals = '{64'd0, 64'd1, 64'h8000_0000, 64'h8000_0000_0000_0000,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                  64'h0000_0000_0040_0000, 64'h43E0_0000_0000_0000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: each opcode on one boundary operand, extra cases for some opcodes, plus unused opcodes.
    for (int i = 0; i < 10; i++) send_beat(4'(i), edge_vals[i % 8]);
    send_beat(fifc_pkg::OP_F32_F64, 64'h0000_0000_7FC0_0001);
    send_beat(fifc_pkg::OP_F32_F64, 64'hFFFF_FFFF_8000_0000);
    send_beat(fifc_pkg::OP_F64_F32, 64'h3800_0000_0000_0000);
    send_beat(fifc_pkg::OP_F64_F32, 64'hC7F0_0000_0000_0000);
    send_beat(fifc_pkg::OP_F64_F32, 64'h7FF0_0000_0000_0001);
    send_beat(fifc_pkg::OP_F64_U32, 64'hBFF0_0000_0000_0000);
    send_beat(fifc_pkg::OP_F64_S64, 64'h3FEF_FFFF_FFFF_FFFF);
    send_beat(fifc_pkg::OP_F64_S64, 64'hC3E0_0000_0000_0000);
    send_beat(4'd10, 64'h1234);
    send_beat(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    // Sender pauses until everything has come back.
    drain();
    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 40;
    for (int i = 0; i < 20; i++) send_beat(4'($urandom_range(9)), rand64());
    drain();
    for (int i = 0; i < 630; i++) begin
      calm = (i >= 200 && i < 300);
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      send_beat(op, rand_operand(op));
    end
    calm = 0;
    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
